// ===== design/block_cache_batch_evict_top_defines.svh =====
// Assertion macros used by block_cache_batch_evict_top.
`ifndef BLOCK_CACHE_BATCH_EVICT_TOP_DEFINES_SVH
`define BLOCK_CACHE_BATCH_EVICT_TOP_DEFINES_SVH

// Check an implication in the same cycle.
`define BCE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check an implication in the next cycle.
`define BCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/bce_pkg.sv =====
package bce_pkg;

  localparam int ENTRIES    = 256;
  localparam int DATA_WIDTH = 64;
  localparam int KEY_WIDTH  = 32;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CNT_W      = $clog2(ENTRIES + 1);

  localparam int CFG_W      = 9;
  localparam int CFG_ADDR_W = 1;
  localparam int KEY_IN_W   = 32;
  localparam int DATA_IN_W  = 64;
  localparam int WCNT_W     = 32;
  localparam int S_TDATA_W  = 96;
  localparam int M_TDATA_W  = 120;

  localparam logic [CFG_ADDR_W-1:0] REG_CAPACITY = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_BATCH    = CFG_ADDR_W'(1);

  localparam logic [CFG_W-1:0] CAPACITY_RST = CFG_W'(256);
  localparam logic [CFG_W-1:0] BATCH_RST    = CFG_W'(16);

  typedef enum logic [0:0] {
    CMD_QUERY  = 1'b0,
    CMD_INSERT = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DISPATCH,
    ST_QREAD,
    ST_EVICT,
    ST_EVICT_WB,
    ST_ALLOC,
    ST_ALLOC_WB,
    ST_FINISH,
    ST_CLEAR
  } state_t;

endpackage

// ===== design/bce_ram.sv =====
module bce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/block_cache_batch_evict_top.sv =====
// Channel   Dir  tdata                               tuser
// s_axis    in   blk_num, data_word                  cmd
// m_axis    out  data_out, evicted, occupancy, wcnt  hit
// cfg       in   write port: capacity (0), batch (1)
//
// Scan the key memory one entry a cycle: a hit ends the scan early, a miss scans every entry.
// Dispatch and finish follow the scan; a query hit adds one payload read.
// An insert miss evicts entries through the evict and write-back states, then checks for and grabs a slot.
// Reset is synchronous; a clearing pass over all ENTRIES entries follows with s_tready low.
// s_tready is high only in idle; finish holds until the output register is free.
`include "block_cache_batch_evict_top_defines.svh"

module block_cache_batch_evict_top
  import bce_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // blk_num, data_word
  input  logic                  s_tuser,   // cmd
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // data_out, evicted_count, occupancy,
                                           // write_count, zero pad
  output logic                  m_tuser,   // hit
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W:0]   SLOTS_C   = (CNT_W + 1)'(ENTRIES);

  state_t state, state_next;

  logic [CFG_W-1:0]      cap_reg, batch_reg;
  cmd_t                  cmd_q;
  logic [KEY_WIDTH-1:0]  key_q;
  logic [DATA_WIDTH-1:0] data_q;
  logic [CNT_W-1:0]      scan_idx;
  logic                  cmp_vld;
  logic [IDX_W-1:0]      cmp_idx;
  logic                  hit_q;
  logic [IDX_W-1:0]      slot_q;
  logic [IDX_W-1:0]      head;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      free_top;
  logic [WCNT_W-1:0]     writes;
  logic [CNT_W-1:0]      evicted;
  logic [CNT_W-1:0]      target;
  logic [CNT_W-1:0]      cap_q;
  logic [DATA_WIDTH-1:0] dout_q;
  logic [IDX_W-1:0]      clr_idx;

  logic [KEY_WIDTH:0]    key_rdata;
  logic [DATA_WIDTH-1:0] pay_rdata;
  logic [IDX_W-1:0]      age_rdata;
  logic [IDX_W-1:0]      free_rdata;

  logic                  match, scan_last;
  logic [CNT_W-1:0]      cap_c, batch_c, free_c, target_c;
  logic [CNT_W-1:0]      ft_dec;
  logic [CNT_W:0]        tail_sum;
  logic [CNT_W:0]        slot_sum;
  logic [IDX_W-1:0]      tail;
  logic [IDX_W-1:0]      alloc_slot;
  logic                  evict_go, alloc_go, out_free;

  logic                  key_we, pay_we, age_we, free_we;
  logic [IDX_W-1:0]      pay_waddr;
  logic [IDX_W-1:0]      key_waddr;
  logic [KEY_WIDTH:0]    key_wdata;
  logic [IDX_W-1:0]      free_waddr;
  logic [IDX_W-1:0]      free_wdata;

  bce_ram #(.WIDTH(KEY_WIDTH + 1), .DEPTH(ENTRIES)) u_key_mem (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .raddr(scan_idx[IDX_W-1:0]), .rdata(key_rdata)
  );

  bce_ram #(.WIDTH(DATA_WIDTH), .DEPTH(ENTRIES)) u_pay_mem (
    .clk(clk), .we(pay_we), .waddr(pay_waddr), .wdata(data_q),
    .raddr(slot_q), .rdata(pay_rdata)
  );

  bce_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_age_mem (
    .clk(clk), .we(age_we), .waddr(tail), .wdata(alloc_slot),
    .raddr(head), .rdata(age_rdata)
  );

  bce_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_free_mem (
    .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
    .raddr(ft_dec[IDX_W-1:0]), .rdata(free_rdata)
  );

  always_comb begin
    match     = cmp_vld && key_rdata[KEY_WIDTH] && (key_rdata[KEY_WIDTH-1:0] == key_q);
    scan_last = cmp_vld && (cmp_idx == LAST_IDX);

    if (cap_reg == '0) begin
      cap_c = CNT_W'(1);
    end else if (CNT_W'(cap_reg) > ENTRIES_C) begin
      cap_c = ENTRIES_C;
    end else begin
      cap_c = CNT_W'(cap_reg);
    end
    batch_c  = (batch_reg == '0) ? CNT_W'(1) : CNT_W'(batch_reg);
    free_c   = (cap_c > count) ? (cap_c - count) : '0;
    target_c = (free_c < batch_c) ? batch_c : '0;

    ft_dec   = free_top - CNT_W'(1);
    tail_sum = {1'b0, CNT_W'(head)} + {1'b0, count};
    if (tail_sum >= (CNT_W + 1)'(ENTRIES)) begin
      tail = IDX_W'(tail_sum - (CNT_W + 1)'(ENTRIES));
    end else begin
      tail = IDX_W'(tail_sum);
    end
    slot_sum   = {1'b0, count} + {1'b0, free_top};
    alloc_slot = free_rdata;

    evict_go = (evicted < target) && (count != '0);
    alloc_go = (count < cap_q) && (free_top != '0);
    out_free = !m_tvalid || m_tready;
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    key_we     = 1'b0;
    pay_we     = 1'b0;
    age_we     = 1'b0;
    free_we    = 1'b0;
    pay_waddr  = slot_q;
    key_waddr  = alloc_slot;
    key_wdata  = {1'b1, key_q};
    free_waddr = free_top[IDX_W-1:0];
    free_wdata = age_rdata;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match || scan_last) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (cmd_q == CMD_QUERY) begin
          state_next = hit_q ? ST_QREAD : ST_FINISH;
        end else if (hit_q) begin
          pay_we     = 1'b1;
          state_next = ST_FINISH;
        end else begin
          state_next = ST_EVICT;
        end
      end
      ST_QREAD: state_next = ST_FINISH;
      ST_EVICT: state_next = evict_go ? ST_EVICT_WB : ST_ALLOC;
      ST_EVICT_WB: begin
        key_we     = 1'b1;
        key_waddr  = age_rdata;
        key_wdata  = '0;
        free_we    = free_top < ENTRIES_C;
        state_next = ST_EVICT;
      end
      ST_ALLOC: state_next = alloc_go ? ST_ALLOC_WB : ST_FINISH;
      ST_ALLOC_WB: begin
        key_we     = 1'b1;
        pay_we     = 1'b1;
        age_we     = 1'b1;
        pay_waddr  = alloc_slot;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        key_we     = 1'b1;
        key_waddr  = clr_idx;
        key_wdata  = '0;
        free_we    = 1'b1;
        free_waddr = clr_idx;
        free_wdata = clr_idx;
        if (clr_idx == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg   <= CAPACITY_RST;
      batch_reg <= BATCH_RST;
    end else if (cfg_we) begin
      if (cfg_addr == REG_CAPACITY) begin
        cap_reg <= cfg_wdata;
      end else if (cfg_addr == REG_BATCH) begin
        batch_reg <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      free_top <= ENTRIES_C;
      writes   <= '0;
      m_tvalid <= 1'b0;
      cmp_vld  <= 1'b0;
      clr_idx  <= '0;
    end else begin
      if (state == ST_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd_q    <= cmd_t'(s_tuser);
            key_q    <= KEY_WIDTH'(s_tdata[KEY_IN_W-1:0]);
            data_q   <= DATA_WIDTH'(s_tdata[KEY_IN_W +: DATA_IN_W]);
            scan_idx <= '0;
            cmp_vld  <= 1'b0;
            evicted  <= '0;
            hit_q    <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (scan_idx < ENTRIES_C) begin
            scan_idx <= scan_idx + CNT_W'(1);
            cmp_vld  <= 1'b1;
            cmp_idx  <= scan_idx[IDX_W-1:0];
          end else begin
            cmp_vld <= 1'b0;
          end
          if (match) begin
            hit_q  <= 1'b1;
            slot_q <= cmp_idx;
          end
        end
        ST_DISPATCH: begin
          dout_q <= '0;
          target <= target_c;
          cap_q  <= cap_c;
          if (cmd_q == CMD_INSERT) begin
            writes <= writes + WCNT_W'(1);
          end
        end
        ST_QREAD: dout_q <= pay_rdata;
        ST_EVICT: ;
        ST_EVICT_WB: begin
          if (free_top < ENTRIES_C) begin
            free_top <= free_top + CNT_W'(1);
          end
          head    <= (head == LAST_IDX) ? '0 : head + IDX_W'(1);
          count   <= count - CNT_W'(1);
          evicted <= evicted + CNT_W'(1);
        end
        ST_ALLOC: ;
        ST_ALLOC_WB: begin
          count    <= count + CNT_W'(1);
          free_top <= ft_dec;
        end
        ST_FINISH: begin
          if (out_free) begin
            m_tuser  <= hit_q;
            m_tdata  <= M_TDATA_W'({WCNT_W'(writes), 9'(count), 9'(evicted),
                                    DATA_IN_W'(dout_q)});
          end
        end
        ST_CLEAR: clr_idx <= clr_idx + IDX_W'(1);
        default: ;
      endcase
    end
  end

  `BCE_ASSERT_NOW(a_slot_balance, 1'b1, slot_sum == SLOTS_C, "slot count mismatch")
  `BCE_ASSERT_NOW(a_evict_nonempty, state == ST_EVICT_WB, count != '0, "evict from empty ring")
  `BCE_ASSERT_NOW(a_miss_zero, m_tvalid && !m_tuser, m_tdata[DATA_IN_W-1:0] == '0, "miss data")
  `BCE_ASSERT_NEXT(a_finish_out, state == ST_FINISH && out_free, m_tvalid, "result dropped")

endmodule
